// ----- rtl/core/gmfc_pkg.sv -----
// ----------------------------------------------------------------------------
// gmfc_pkg
// Shared types, constants and per-axis mapping functions of the gesture
// motion to flight command unit.
// ----------------------------------------------------------------------------
package gmfc_pkg;

   // Raw sample width and axis order inside a sample word
   localparam int SAMPLE_W = 16;
   localparam int AXIS_AX  = 0;
   localparam int AXIS_AY  = 1;
   localparam int AXIS_AZ  = 2;
   localparam int AXIS_GZ  = 3;

   // Sample kinds carried on the request tuser
   localparam logic CMD_CAL     = 1'b0;
   localparam logic CMD_CONTROL = 1'b1;

   // Register indexes of the csr port
   localparam logic [1:0] REG_DEADZONE  = 2'd0;
   localparam logic [1:0] REG_ALPHA     = 2'd1;
   localparam logic [1:0] REG_ARM_THRES = 2'd2;

   // Register reset values
   localparam logic [14:0] DEADZONE_RESET  = 15'd1200;
   localparam logic [8:0]  ALPHA_RESET     = 9'd77;
   localparam logic [10:0] ARM_THRES_RESET = 11'd1080;

   // Filter gain is in units of 1/256
   localparam logic [8:0] ALPHA_ONE   = 9'd256;
   localparam int         ALPHA_SHIFT = 8;

   // Mapping: input span +-8000, attitude span +-300, throttle 1000..2000
   localparam logic signed [16:0] IN_LIMIT  = 17'sd8000;
   localparam int                 ATT_SPAN  = 300;
   localparam logic [10:0]        THR_BASE  = 11'd1000;
   localparam int                 THR_TOP   = 2000;
   // floor(u / 5) for u < 4096 as (u * ceil(2^15 / 5)) >> 15
   localparam logic [24:0]        DIV5_RECIP = 25'd6554;
   localparam int                 DIV5_SHIFT = 15;

   typedef logic [3:0][SAMPLE_W-1:0] axis4_type;

   // Mapped targets, one beat between the map and filter stages
   typedef struct packed {
      logic                cal_done;
      logic                is_control;
      logic [10:0]         throttle;
      logic signed [9:0]   pitch;
      logic signed [9:0]   roll;
      logic signed [9:0]   yaw;
   } target_type;

   // One result beat
   typedef struct packed {
      logic                cal_done;
      logic                is_control;
      logic                arm_request;
      logic [10:0]         throttle;
      logic signed [9:0]   pitch;
      logic signed [9:0]   roll;
      logic signed [9:0]   yaw;
   } result_type;

   // Offset removal (16-bit wrap), deadzone, clamp to +-8000, then bias to 0..16000
   function automatic logic [13:0] shift_axis(input logic [15:0] raw,
                                              input logic [15:0] off,
                                              input logic [14:0] dz);
      logic [15:0]        rel;
      logic signed [16:0] r17;
      logic signed [16:0] d17;
      logic signed [16:0] v;
      logic signed [16:0] biased;
      rel = raw - off;
      r17 = 17'($signed(rel));
      d17 = $signed({2'b00, dz});
      if (r17 > -d17 && r17 < d17) begin
         v = 17'sd0;
      end else begin
         v = r17;
      end
      if (v > IN_LIMIT) begin
         v = IN_LIMIT;
      end else if (v < -IN_LIMIT) begin
         v = -IN_LIMIT;
      end
      biased = v + IN_LIMIT;
      return biased[13:0];
   endfunction

   // floor(600 * w / 16000) - 300 = floor(floor(3w / 16) / 5) - 300
   function automatic logic signed [9:0] att_target(input logic [13:0] w);
      logic [15:0]        t3;
      logic [11:0]        u;
      logic [24:0]        p;
      logic [9:0]         q;
      logic signed [10:0] s;
      t3 = 16'(w) * 16'd3;
      u  = t3[15:4];
      p  = 25'(u) * DIV5_RECIP;
      q  = p[DIV5_SHIFT +: 10];
      s  = $signed({1'b0, q}) - 11'(ATT_SPAN);
      return s[9:0];
   endfunction

   // floor(1000 * w / 16000) + 1000
   function automatic logic [10:0] thr_target(input logic [13:0] w);
      return 11'(w[13:4]) + THR_BASE;
   endfunction

endpackage

// ----- rtl/core/gmfc_cal_unit.sv -----
// ----------------------------------------------------------------------------
// gmfc_cal_unit
// Calibration accumulators, sample counter and offset divider. The divide
// by the sample count runs in the cycle after the last calibration beat.
// ----------------------------------------------------------------------------
module gmfc_cal_unit #(
   parameter int CAL_SAMPLES = 300
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,      // calibration beat enters the map stage
   input  gmfc_pkg::axis4_type sample,
   output gmfc_pkg::axis4_type offsets,
   output logic                done,      // this beat completes a calibration run
   output logic                busy       // divider cycle, hold the pipeline
);
   import gmfc_pkg::*;

   localparam int CNT_W  = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
   localparam int SUM_W  = SAMPLE_W + $clog2(CAL_SAMPLES + 1);
   localparam int MAG_W  = SUM_W - 1;
   localparam int DIV_L  = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 0;
   localparam int DIV_SH = MAG_W + DIV_L;
   localparam int REC_W  = MAG_W + 1;
   localparam int PROD_W = MAG_W + REC_W;
   // ceil(2^DIV_SH / CAL_SAMPLES): exact floor divide for magnitudes below 2^MAG_W
   localparam logic [63:0] DIV_ONE   = 64'd1 << DIV_SH;
   localparam logic [63:0] DIV_RECIP = (DIV_ONE + 64'(CAL_SAMPLES) - 64'd1)
                                       / 64'(CAL_SAMPLES);
   localparam logic [REC_W-1:0] RECIP = DIV_RECIP[REC_W-1:0];

   logic signed [SUM_W-1:0]  sum_ff   [4];
   logic signed [SUM_W-1:0]  sum_in   [4];
   logic signed [SUM_W-1:0]  sum_new  [4];
   logic [MAG_W-1:0]         mag_ff   [4];
   logic [MAG_W-1:0]         mag_in   [4];
   logic [3:0]               neg_ff;
   logic [3:0]               neg_in;
   logic [PROD_W-1:0]        prod     [4];
   logic [SAMPLE_W-1:0]      quo      [4];
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         cnt_in;
   logic                     busy_ff;
   logic                     busy_in;
   axis4_type                off_ff;
   axis4_type                off_in;
   logic                     last_sample;

   assign last_sample = (cnt_ff == CNT_W'(CAL_SAMPLES - 1));
   assign done        = step && last_sample;
   assign busy        = busy_ff;
   assign offsets     = off_ff;
   assign busy_in     = done;

   // Running sums and magnitude/sign of the final sums
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum_new[i] = sum_ff[i] + SUM_W'($signed(sample[i]));
         if (sum_new[i] < 0) begin
            mag_in[i] = MAG_W'(-sum_new[i]);
         end else begin
            mag_in[i] = MAG_W'(sum_new[i]);
         end
         neg_in[i] = sum_new[i] < 0;
         if (!step) begin
            sum_in[i] = sum_ff[i];
         end else if (last_sample) begin
            sum_in[i] = '0;
         end else begin
            sum_in[i] = sum_new[i];
         end
      end
   end

   // Counter
   always_comb begin
      if (!step) begin
         cnt_in = cnt_ff;
      end else if (last_sample) begin
         cnt_in = '0;
      end else begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Reciprocal multiply, truncate toward zero
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod[i]   = PROD_W'(mag_ff[i]) * PROD_W'(RECIP);
         quo[i]    = prod[i][DIV_SH +: SAMPLE_W];
         off_in[i] = neg_ff[i] ? -quo[i] : quo[i];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= '0;
         end
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         off_ff  <= '0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= sum_in[i];
         end
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         if (busy_ff) begin
            off_ff <= off_in;
         end
      end
   end

   // Divider operands
   always_ff @(posedge clock) begin
      if (done) begin
         for (int i = 0; i < 4; i++) begin
            mag_ff[i] <= mag_in[i];
         end
         neg_ff <= neg_in;
      end
   end

`ifndef ASSERT_OFF
   // divider busy flag drops again in the cycle after it rises
   a_busy_single: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("divider busy for more than one cycle");

   // pipeline must hold while offsets are being computed
   a_no_step_busy: assert property (@(posedge clock) disable iff (reset)
      !(step && busy_ff))
      else $error("calibration beat taken during divide");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAL_SAMPLES - 1))
      else $error("calibration count out of range");
`endif

endmodule

// ----- rtl/core/gmfc_map_stage.sv -----
// ----------------------------------------------------------------------------
// gmfc_map_stage
// Offset removal, deadzone and linear mapping of the four axes to flight
// targets, registered into the map stage.
// ----------------------------------------------------------------------------
module gmfc_map_stage (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   cmd,
   input  gmfc_pkg::axis4_type    sample,
   input  gmfc_pkg::axis4_type    offsets,
   input  logic [14:0]            deadzone,
   input  logic                   cal_done,
   output gmfc_pkg::target_type   target
);
   import gmfc_pkg::*;

   logic [13:0] w [4];
   target_type  tgt_ff;
   target_type  tgt_in;

   // Per-axis offset, deadzone, clamp and bias
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         w[i] = shift_axis(sample[i], offsets[i], deadzone);
      end
   end

   // Pitch from accel y, roll from accel x, yaw from gyro z, throttle from accel z
   always_comb begin
      tgt_in.cal_done   = cal_done;
      tgt_in.is_control = (cmd == CMD_CONTROL);
      tgt_in.throttle   = thr_target(w[AXIS_AZ]);
      tgt_in.pitch      = att_target(w[AXIS_AY]);
      tgt_in.roll       = att_target(w[AXIS_AX]);
      tgt_in.yaw        = att_target(w[AXIS_GZ]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tgt_ff <= tgt_in;
      end
   end

   assign target = tgt_ff;

endmodule

// ----- rtl/core/gmfc_filter_stage.sv -----
// ----------------------------------------------------------------------------
// gmfc_filter_stage
// First-order low-pass filters of the four flight channels and the result
// register.
// ----------------------------------------------------------------------------
module gmfc_filter_stage #(
   parameter int FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  gmfc_pkg::target_type   target,
   input  logic [8:0]             alpha,
   input  logic [10:0]            arm_thres,
   output gmfc_pkg::result_type   result
);
   import gmfc_pkg::*;

   localparam int ATT_W  = 10 + FRAC_BITS;
   localparam int THR_W  = 11 + FRAC_BITS;
   localparam int ATT_PW = ATT_W + 11;
   localparam int THR_PW = THR_W + 12;
   localparam logic signed [ATT_W-1:0] ATT_LIMIT = ATT_W'(ATT_SPAN) << FRAC_BITS;
   localparam logic [THR_W-1:0] THR_LO = THR_W'(THR_BASE) << FRAC_BITS;
   localparam logic [THR_W-1:0] THR_HI = THR_W'(THR_TOP) << FRAC_BITS;

   logic signed [ATT_W-1:0]  att_f_ff  [3];
   logic signed [ATT_W-1:0]  att_f_in  [3];
   logic signed [ATT_W-1:0]  att_tgt   [3];
   logic signed [ATT_W:0]    att_diff  [3];
   logic signed [ATT_PW-1:0] att_prod  [3];
   logic signed [ATT_PW-1:0] att_step  [3];
   logic signed [ATT_W-1:0]  att_whole [3];
   logic signed [ATT_W-1:0]  att_int   [3];
   logic [THR_W-1:0]         thr_f_ff;
   logic [THR_W-1:0]         thr_f_in;
   logic [THR_W-1:0]         thr_tgt;
   logic signed [THR_PW-1:0] thr_diff;
   logic signed [THR_PW-1:0] thr_prod;
   logic signed [THR_PW-1:0] thr_sum;
   logic [10:0]              thr_int;
   logic signed [ATT_PW-1:0] alpha_att;
   logic signed [THR_PW-1:0] alpha_thr;
   result_type               res_ff;
   result_type               res_in;

   assign alpha_att  = ATT_PW'($signed({1'b0, alpha}));
   assign alpha_thr  = THR_PW'($signed({1'b0, alpha}));
   assign att_tgt[0] = ATT_W'(target.pitch) <<< FRAC_BITS;
   assign att_tgt[1] = ATT_W'(target.roll) <<< FRAC_BITS;
   assign att_tgt[2] = ATT_W'(target.yaw) <<< FRAC_BITS;

   // Attitude filters: f + floor(alpha * (target - f) / 256)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         att_diff[i] = (ATT_W + 1)'(att_tgt[i]) - (ATT_W + 1)'(att_f_ff[i]);
         att_prod[i] = ATT_PW'(att_diff[i]) * alpha_att;
         att_step[i] = att_prod[i] >>> ALPHA_SHIFT;
         if (target.is_control) begin
            att_f_in[i] = att_f_ff[i] + ATT_W'(att_step[i]);
         end else begin
            att_f_in[i] = att_f_ff[i];
         end
         // integer part, truncated toward zero
         att_whole[i] = att_f_in[i] >>> FRAC_BITS;
         if (att_f_in[i][ATT_W-1] && (|att_f_in[i][FRAC_BITS-1:0])) begin
            att_int[i] = att_whole[i] + 1'b1;
         end else begin
            att_int[i] = att_whole[i];
         end
      end
   end

   // Throttle filter, always positive
   always_comb begin
      thr_tgt  = THR_W'(target.throttle) << FRAC_BITS;
      thr_diff = THR_PW'($signed({1'b0, thr_tgt})) - THR_PW'($signed({1'b0, thr_f_ff}));
      thr_prod = thr_diff * alpha_thr;
      thr_sum  = THR_PW'($signed({1'b0, thr_f_ff})) + (thr_prod >>> ALPHA_SHIFT);
      if (target.is_control) begin
         thr_f_in = thr_sum[THR_W-1:0];
      end else begin
         thr_f_in = thr_f_ff;
      end
      thr_int = thr_f_in[THR_W-1:FRAC_BITS];
   end

   // Result beat
   always_comb begin
      res_in.cal_done    = target.cal_done;
      res_in.is_control  = target.is_control;
      res_in.arm_request = thr_int < arm_thres;
      res_in.throttle    = thr_int;
      res_in.pitch       = att_int[0][9:0];
      res_in.roll        = att_int[1][9:0];
      res_in.yaw         = att_int[2][9:0];
   end

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            att_f_ff[i] <= '0;
         end
         thr_f_ff <= THR_LO;
      end else if (load) begin
         for (int i = 0; i < 3; i++) begin
            att_f_ff[i] <= att_f_in[i];
         end
         thr_f_ff <= thr_f_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

`ifndef ASSERT_OFF
   // filters never leave the span of their targets
   a_att_range: assert property (@(posedge clock) disable iff (reset)
      att_f_ff[0] <= ATT_LIMIT && att_f_ff[0] >= -ATT_LIMIT &&
      att_f_ff[1] <= ATT_LIMIT && att_f_ff[1] >= -ATT_LIMIT &&
      att_f_ff[2] <= ATT_LIMIT && att_f_ff[2] >= -ATT_LIMIT)
      else $error("attitude filter out of range");

   a_thr_range: assert property (@(posedge clock) disable iff (reset)
      thr_f_ff >= THR_LO && thr_f_ff <= THR_HI)
      else $error("throttle filter out of range");
`endif

endmodule

// ----- rtl/core/gesture_motion_to_flight_command_unit.sv -----
// ----------------------------------------------------------------------------
// gesture_motion_to_flight_command_unit
// Turns raw accel/gyro samples into filtered throttle, pitch, roll and yaw.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per sensor sample. req_tuser is 0 for a calibration
//   sample, 1 for a control sample. Every request beat gives one rsp beat.
//   csr channel: register writes (deadzone, filter alpha, arm threshold),
//   always ready; write only while no beats are in flight.
//   Pipeline: input register, map stage (offset, deadzone, scale), filter
//   stage with the result register. A taken request beat passes through each
//   of them in turn before rsp_tvalid rises.
//   Throughput: one beat per cycle while rsp_tready is high and the divider
//   is idle. A calibration beat that completes a run starts the offset
//   divider (one reciprocal multiply per axis), which holds the map stage.
//   Stalls: while rsp_tready is low the stages fill up; req_tready drops only
//   when the input register is full and cannot move on.
//   Reset: registers to their defaults, offsets and sums cleared, attitude
//   filters at 0, throttle filter at 1000; no clearing pass.
// ----------------------------------------------------------------------------
module gesture_motion_to_flight_command_unit #(
   parameter int CAL_SAMPLES = 300,
   parameter int FRAC_BITS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // accel_x, accel_y, accel_z, gyro_z
   input  logic        req_tuser,   // command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // throttle_out, pitch_out, roll_out, yaw_out,
                                    // arm_request, calibration_done, zero pad
   output logic        rsp_tuser,   // is_control
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);
   import gmfc_pkg::*;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic        s1_cmd_ff;
   axis4_type   s1_sample_ff;
   logic        s2_valid_ff;
   logic        s2_valid_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [14:0] deadzone_ff;
   logic [8:0]  alpha_ff;
   logic [8:0]  alpha_in;
   logic [10:0] arm_thres_ff;
   logic        req_accept;
   logic        s2_move;
   logic        out_move;
   logic        cal_step;
   logic        cal_done;
   logic        cal_busy;
   axis4_type   offsets;
   target_type  target;
   result_type  result;

   // Pipeline advance
   assign out_move   = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign s2_move    = s1_valid_ff && !cal_busy && (!s2_valid_ff || out_move);
   assign req_tready = !s1_valid_ff || s2_move;
   assign req_accept = req_tvalid && req_tready;
   assign cal_step   = s2_move && (s1_cmd_ff == CMD_CAL);

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_move);
   assign s2_valid_in  = s2_move || (s2_valid_ff && !out_move);
   assign out_valid_in = out_move || (out_valid_ff && !rsp_tready);

   // Gain above unity saturates
   assign alpha_in = (csr_data[8:0] > ALPHA_ONE) ? ALPHA_ONE : csr_data[8:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         deadzone_ff  <= DEADZONE_RESET;
         alpha_ff     <= ALPHA_RESET;
         arm_thres_ff <= ARM_THRES_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_DEADZONE:  deadzone_ff  <= csr_data;
               REG_ALPHA:     alpha_ff     <= alpha_in;
               REG_ARM_THRES: arm_thres_ff <= csr_data[10:0];
               default: ;
            endcase
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff    <= req_tuser;
         s1_sample_ff <= req_tdata;
      end
   end

   gmfc_cal_unit #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_cal (
      .clock   (clock),
      .reset   (reset),
      .step    (cal_step),
      .sample  (s1_sample_ff),
      .offsets (offsets),
      .done    (cal_done),
      .busy    (cal_busy)
   );

   gmfc_map_stage u_map (
      .clock    (clock),
      .load     (s2_move),
      .cmd      (s1_cmd_ff),
      .sample   (s1_sample_ff),
      .offsets  (offsets),
      .deadzone (deadzone_ff),
      .cal_done (cal_done),
      .target   (target)
   );

   gmfc_filter_stage #(
      .FRAC_BITS (FRAC_BITS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .load      (out_move),
      .target    (target),
      .alpha     (alpha_ff),
      .arm_thres (arm_thres_ff),
      .result    (result)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result.is_control;
   assign rsp_tdata  = {5'b0, result.cal_done, result.arm_request, result.yaw,
                        result.roll, result.pitch, result.throttle};

endmodule

// ----- tb/sv/tb_gesture_motion_to_flight_command_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gesture_motion_to_flight_command_unit
// Self-checking bench for the gesture to flight command unit. Sensor samples
// go in as stream beats with random gaps while the result side stalls at
// random. A tracker class recomputes offsets, deadzone, mapping and the
// low-pass filters for every accepted sample and checks each result beat in
// order. Phases between register writes cover the register extremes and full
// offset calibration runs.
// ----------------------------------------------------------------------------
module tb_gesture_motion_to_flight_command_unit;
   import gmfc_pkg::*;

   localparam int         CAL_RUN     = 300;
   localparam int         FRAC_W      = 8;
   localparam int         STALL_LIMIT = 4000;
   localparam int         CTRL_BEATS  = 120;
   // index with no register behind it
   localparam logic [1:0] REG_UNUSED  = 2'd3;

   // One expected result
   typedef struct {
      logic [10:0]       throttle;
      logic signed [9:0] pitch;
      logic signed [9:0] roll;
      logic signed [9:0] yaw;
      logic              arm;
      logic              is_control;
      logic              cal_done;
   } flight_cmd_type;

   // Tracks offsets, filters and registers; queues and checks commands
   class flight_cmd_tracker_type;
      int             deadzone;
      int             alpha;
      int             arm_thr;
      int             sums[4];
      int             cal_count;
      logic [15:0]    offsets[4];
      longint         att_filt[3];
      longint         thr_filt;
      flight_cmd_type expected_q[$];
      int             errors;
      int             samples;
      int             controls;
      int             cal_runs;
      int             reg_writes;
      int             beats_checked;

      function new();
         deadzone = DEADZONE_RESET;
         alpha    = ALPHA_RESET;
         arm_thr  = ARM_THRES_RESET;
         for (int k = 0; k < 4; k++) begin
            sums[k]    = 0;
            offsets[k] = '0;
         end
         for (int k = 0; k < 3; k++) begin
            att_filt[k] = 0;
         end
         cal_count = 0;
         thr_filt  = longint'(1000) <<< FRAC_W;
      endfunction

      function void apply_reg(logic [1:0] idx, logic [14:0] val);
         reg_writes++;
         case (idx)
            REG_DEADZONE:  deadzone = val;
            REG_ALPHA:     alpha    = val[8:0];
            REG_ARM_THRES: arm_thr  = val[10:0];
            default: ;
         endcase
      endfunction

      // offset removal with 16-bit wrap, then deadzone
      function int centered(logic [15:0] raw, int k);
         logic [15:0] d;
         int          r;
         d = raw - offsets[k];
         r = int'($signed(d));
         if (r > -deadzone && r < deadzone) begin
            r = 0;
         end
         return r;
      endfunction

      function int attitude_target(int x);
         int v;
         v = (x + 8000) * 600 / 16000 - 300;
         if (v < -300) v = -300;
         if (v > 300) v = 300;
         return v;
      endfunction

      function int throttle_target(int x);
         int v;
         v = (x + 8000) * 1000 / 16000 + 1000;
         if (v < 1000) v = 1000;
         if (v > 2000) v = 2000;
         return v;
      endfunction

      // f + floor(alpha * (target - f) / 256); alpha saturates at one
      function longint smooth(longint f, int target);
         longint a;
         longint t;
         a = (alpha > 256) ? 256 : alpha;
         t = longint'(target) <<< FRAC_W;
         return f + ((a * (t - f)) >>> ALPHA_SHIFT);
      endfunction

      function void take_sample(logic cmd, logic [63:0] data);
         logic [15:0]    ax[4];
         flight_cmd_type e;
         logic           done;
         longint         q;
         for (int k = 0; k < 4; k++) begin
            ax[k] = data[16*k +: 16];
         end
         done = 1'b0;
         samples++;
         if (cmd == CMD_CAL) begin
            for (int k = 0; k < 4; k++) begin
               sums[k] += int'($signed(ax[k]));
            end
            if (cal_count + 1 >= CAL_RUN) begin
               for (int k = 0; k < 4; k++) begin
                  offsets[k] = 16'(sums[k] / CAL_RUN);
                  sums[k]    = 0;
               end
               cal_count = 0;
               done      = 1'b1;
               cal_runs++;
            end else begin
               cal_count++;
            end
         end else begin
            controls++;
            // pitch from accel y, roll from accel x, yaw from gyro z
            att_filt[0] = smooth(att_filt[0], attitude_target(centered(ax[1], 1)));
            att_filt[1] = smooth(att_filt[1], attitude_target(centered(ax[0], 0)));
            att_filt[2] = smooth(att_filt[2], attitude_target(centered(ax[3], 3)));
            thr_filt    = smooth(thr_filt, throttle_target(centered(ax[2], 2)));
         end
         q = thr_filt / (longint'(1) <<< FRAC_W);
         e.throttle = q[10:0];
         e.arm      = (q < arm_thr);
         q = att_filt[0] / (longint'(1) <<< FRAC_W);
         e.pitch    = q[9:0];
         q = att_filt[1] / (longint'(1) <<< FRAC_W);
         e.roll     = q[9:0];
         q = att_filt[2] / (longint'(1) <<< FRAC_W);
         e.yaw      = q[9:0];
         e.is_control = cmd;
         e.cal_done   = done;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_command(logic [47:0] d, logic user);
         flight_cmd_type e;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: tdata %h", d);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         beats_checked++;
         compare_field("throttle_out", e.throttle, d[10:0]);
         compare_field("pitch_out", e.pitch, $signed(d[20:11]));
         compare_field("roll_out", e.roll, $signed(d[30:21]));
         compare_field("yaw_out", e.yaw, $signed(d[40:31]));
         compare_field("arm_request", e.arm, d[41]);
         compare_field("calibration_done", e.cal_done, d[42]);
         compare_field("is_control", e.is_control, user);
         compare_field("tdata pad", 0, d[47:43]);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = CMD_CAL;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = REG_DEADZONE;
   logic [14:0] csr_data   = '0;

   bit                     idle_on  = 1'b1;
   bit                     stall_on = 1'b1;
   int                     quiet_cycles = 0;
   flight_cmd_tracker_type tracker = new();

   gesture_motion_to_flight_command_unit #(
      .CAL_SAMPLES (CAL_RUN),
      .FRAC_BITS   (FRAC_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // mostly no gap, some short ones, a few long
   function automatic int pause_len(bit on);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!on || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] pack4(logic [15:0] ax, logic [15:0] ay,
                                         logic [15:0] az, logic [15:0] gz);
      return {gz, az, ay, ax};
   endfunction

   // control axis: offset plus a gesture, deadzone edges, extremes or noise
   function automatic logic [15:0] gesture_axis(logic [15:0] off, int dz);
      int          rel;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         return 16'($urandom);
      end else if (pick < 5) begin
         rel = dz - int'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) rel = -rel;
      end else if (pick < 7) begin
         rel = (dz > 1) ? int'($urandom_range(0, 2 * dz - 2)) - (dz - 1) : 0;
      end else if (pick < 18) begin
         rel = int'($urandom_range(0, 18000)) - 9000;
      end else begin
         case ($urandom_range(0, 5))
            0:       rel = 8000;
            1:       rel = -8000;
            2:       rel = 8001;
            3:       rel = -8001;
            4:       rel = 32767;
            default: rel = -32768;
         endcase
      end
      return off + 16'(rel);
   endfunction

   // one request beat, waits for the handshake
   task automatic send_sample(logic cmd, logic [63:0] word);
      int n;
      n = pause_len(idle_on);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [14:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.apply_reg(idx, val);
   endtask

   task automatic program_regs(int dz, int al, int arm, bit extra);
      csr_write(REG_DEADZONE, 15'(dz));
      csr_write(REG_ALPHA, 15'(al));
      csr_write(REG_ARM_THRES, 15'(arm));
      if (extra) csr_write(REG_UNUSED, 15'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      // let the last accepted beat reach the tracker queue before polling it
      @(posedge clock);
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // calibration burst (completing a run where asked), then control traffic with stray calibration beats
   task automatic run_phase(bit finish_run, bit wide);
      logic [15:0] bias[4];
      logic [15:0] ax[4];
      int          n_cal;
      for (int k = 0; k < 4; k++) begin
         bias[k] = 16'(int'($urandom_range(0, 8000)) - 4000);
      end
      n_cal = finish_run ? CAL_RUN - tracker.cal_count : $urandom_range(0, 8);
      for (int i = 0; i < n_cal; i++) begin
         for (int k = 0; k < 4; k++) begin
            ax[k] = wide ? 16'($urandom)
                         : bias[k] + 16'(int'($urandom_range(0, 300)) - 150);
         end
         send_sample(CMD_CAL, pack4(ax[0], ax[1], ax[2], ax[3]));
      end
      for (int i = 0; i < CTRL_BEATS; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_sample(CMD_CAL, {$urandom, $urandom});
         end else begin
            for (int k = 0; k < 4; k++) begin
               ax[k] = gesture_axis(tracker.offsets[k], tracker.deadzone);
            end
            send_sample(CMD_CONTROL, pack4(ax[0], ax[1], ax[2], ax[3]));
         end
      end
   endtask

   // result side: random stalls
   initial begin : rsp_side
      int n;
      while (reset) @(posedge clock);
      forever begin
         n = pause_len(stall_on);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // accepted beats feed the tracker; watchdog on quiet cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.take_sample(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_command(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // main sequence
   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, deadzone edges, mapping edges, calibration beats
      send_sample(CMD_CONTROL, pack4(16'd0, 16'd0, 16'd0, 16'd0));
      send_sample(CMD_CONTROL, {4{16'h7FFF}});
      send_sample(CMD_CONTROL, {4{16'h8000}});
      send_sample(CMD_CONTROL, {4{16'd1199}});
      send_sample(CMD_CONTROL, {4{16'd1200}});
      send_sample(CMD_CONTROL, {4{16'(-1199)}});
      send_sample(CMD_CONTROL, {4{16'(-1200)}});
      send_sample(CMD_CONTROL, pack4(16'd8000, 16'(-8000), 16'd8001, 16'(-8001)));
      send_sample(CMD_CONTROL, pack4(16'(-8001), 16'd8001, 16'(-8000), 16'd8000));
      send_sample(CMD_CONTROL, pack4(16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001));
      send_sample(CMD_CAL, {4{16'h7FFF}});
      send_sample(CMD_CAL, {4{16'h8000}});
      send_sample(CMD_CAL, pack4(16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF));
      send_sample(CMD_CONTROL, {4{16'h7FFF}});
      send_sample(CMD_CONTROL, pack4(16'd0, 16'd0, 16'd0, 16'd0));
      drain_all();

      // register settings per phase, extremes first
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: program_regs(1200, 77, 1080, 1'b0);
            1: program_regs(0, 256, 2001, 1'b0);
            2: program_regs(32767, 1, 1000, 1'b0);
            3: program_regs(1200, 0, 1080, 1'b0);
            4: program_regs(500, 511, 2047, 1'b0);
            5: program_regs($urandom_range(0, 3000), 77, $urandom_range(1000, 2001), 1'b0);
            6: program_regs($urandom_range(0, 3000), 300, 0, 1'b1);
            default: program_regs($urandom_range(0, 32767), $urandom_range(1, 256),
                                  $urandom_range(0, 2047), 1'b0);
         endcase
         idle_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         run_phase(p == 1 || p == 5, p == 5);
         drain_all();
      end
      repeat (10) @(posedge clock);

      $display("run: %0d samples (%0d control), %0d offset runs completed",
               tracker.samples, tracker.controls, tracker.cal_runs);
      $display("run: %0d register writes, %0d result beats checked",
               tracker.reg_writes, tracker.beats_checked);
      if (tracker.expected_q.size() != 0) begin
         $error("%0d expected results never arrived", tracker.expected_q.size());
      end
      if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
